// ----- rtl/slot_ring_buffer_assert.svh -----
// Assertion macros used by the slot ring buffer RTL.
`ifndef SLOT_RING_BUFFER_ASSERT_SVH
`define SLOT_RING_BUFFER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/srb_pkg.sv -----
// Types and constants of the slot ring buffer.
`default_nettype none

package srb_pkg;

    localparam int MAX_SLOTS      = 16;
    localparam int MAX_SLOT_BYTES = 8;
    localparam int IDX_W          = $clog2(MAX_SLOTS);
    localparam int WORD_W         = 8 * MAX_SLOT_BYTES;
    localparam int CNT_W          = 5;
    localparam int SB_W           = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES = 2'd1;

    typedef enum logic [2:0] {
        CMD_PUT       = 3'd0,
        CMD_GET       = 3'd1,
        CMD_PEEK_UNTIL = 3'd2,
        CMD_GET_UNTIL = 3'd3,
        CMD_FLUSH     = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_OUT  = 2'd2
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [WORD_W-1:0] wr_data;
    } t_mem_req;

endpackage

`default_nettype wire

// ----- rtl/srb_slot_mem.sv -----
// Slot store: synchronous memory with per-slot valid bits, unwritten slots read zero.
`default_nettype none

module srb_slot_mem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  srb_pkg::t_mem_req         i_req,
    output logic [srb_pkg::WORD_W-1:0] o_rd_data
);
    import srb_pkg::*;

    logic [WORD_W-1:0]    r_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_valid;
    logic [WORD_W-1:0]    r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_valid[i_req.rd_addr] ? r_mem[i_req.rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/slot_ring_buffer.sv -----
// Slot ring buffer top level: command sequencer, index registers and result register.
//
// Usage:
//   Commands enter on the s_axis channel (tuser = cmd, tdata = write_data,
//   byte_request, delimiter). Each request yields exactly one result on the
//   m_axis channel (tuser = status, tdata = read_data, byte_result,
//   occupancy, is_full, is_empty).
//   Configuration writes use i_cfg_valid/o_cfg_ready with a register index
//   (0 slot_count, 1 slot_bytes) and data; issue them only while idle.
//   Writing slot_count empties the ring; the slot contents are kept.
// Timing:
//   A request reads the slot store in the cycle it is accepted, is executed
//   in the next cycle and shows its result in the cycle after that.
//   One request is in flight at a time, through the registered store read and
//   the result register; a new request is accepted once the last result is taken.
// Reset:
//   Synchronous, active low. The ring is empty, slot_count 16, slot_bytes 8,
//   and all slots read as zero at once through valid bits (no clearing pass).
// Stall:
//   While m_axis_tready is low the result holds and s_axis_tready stays low.
`default_nettype none

module slot_ring_buffer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [79:0]                   s_axis_tdata,  // write_data, byte_request, delimiter
    input  logic [2:0]                    s_axis_tuser,  // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [79:0]                   m_axis_tdata,  // read_data, byte_result, occupancy,
                                                         // is_full, is_empty
    output logic [1:0]                    m_axis_tuser,  // status
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [srb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import srb_pkg::*;

    `include "slot_ring_buffer_assert.svh"

    t_state            r_state, n_state;
    logic              s_accept, exec;

    t_cmd              r_cmd;
    logic [WORD_W-1:0] r_wdata;
    logic [SB_W-1:0]   r_req;
    logic [7:0]        r_delim;

    logic [CNT_W-1:0]  r_slot_count;
    logic [SB_W-1:0]   r_slot_bytes;
    logic [IDX_W-1:0]  r_rd_idx, r_wr_idx, n_rd_idx, n_wr_idx;

    t_status           r_status, n_status;
    logic [WORD_W-1:0] r_rdata, n_rdata;
    logic [SB_W-1:0]   r_bres, n_bres;
    logic [IDX_W-1:0]  r_occ, n_occ;
    logic              r_full, r_empty;

    t_mem_req          mem_req;
    logic [WORD_W-1:0] mem_rdata;

    logic [CNT_W-1:0]  cnt;
    logic [SB_W-1:0]   sb, n_bytes, find_idx, find_len;
    logic              full, empty, found;
    logic [MAX_SLOT_BYTES-1:0] hit;
    logic [CNT_W-1:0]  occ_w;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] n;
        n = CNT_W'(idx) + CNT_W'(1);
        return (n >= c) ? '0 : n[IDX_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] byte_mask(input logic [SB_W-1:0] n);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int k = 0; k < MAX_SLOT_BYTES; k++) begin
            if (SB_W'(k) < n) begin
                m[8*k +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    srb_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_EXEC;
            S_EXEC:  n_state = S_OUT;
            S_OUT:   if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        exec          = 1'b0;
        case (r_state)
            S_IDLE:  s_axis_tready = 1'b1;
            S_EXEC:  exec = 1'b1;
            S_OUT:   m_axis_tvalid = 1'b1;
            default: s_axis_tready = 1'b0;
        endcase
    end

    assign s_accept    = s_axis_tvalid & s_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd   <= t_cmd'(s_axis_tuser);
            r_wdata <= s_axis_tdata[63:0];
            r_req   <= s_axis_tdata[67:64];
            r_delim <= s_axis_tdata[75:68];
        end
    end

    always_comb begin
        if (r_slot_count < CNT_W'(2)) begin
            cnt = CNT_W'(2);
        end else if (r_slot_count > CNT_W'(MAX_SLOTS)) begin
            cnt = CNT_W'(MAX_SLOTS);
        end else begin
            cnt = r_slot_count;
        end
        if (r_slot_bytes == '0) begin
            sb = SB_W'(1);
        end else if (r_slot_bytes > SB_W'(MAX_SLOT_BYTES)) begin
            sb = SB_W'(MAX_SLOT_BYTES);
        end else begin
            sb = r_slot_bytes;
        end
    end

    assign full    = (next_idx(r_wr_idx, cnt) == r_rd_idx);
    assign empty   = (r_rd_idx == r_wr_idx);
    assign n_bytes = (r_req > sb) ? sb : r_req;

    always_comb begin
        for (int k = 0; k < MAX_SLOT_BYTES; k++) begin
            hit[k] = (mem_rdata[8*k +: 8] == r_delim) && (SB_W'(k) < sb);
        end
        found    = 1'b0;
        find_idx = sb;
        for (int k = MAX_SLOT_BYTES - 1; k >= 0; k--) begin
            if (hit[k]) begin
                found    = 1'b1;
                find_idx = SB_W'(k);
            end
        end
        find_len = found ? find_idx + SB_W'(1) : sb;
    end

    always_comb begin
        mem_req.rd_en   = s_accept;
        mem_req.rd_addr = (t_cmd'(s_axis_tuser) == CMD_PUT) ? r_wr_idx : r_rd_idx;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = r_wr_idx;
        mem_req.wr_data = (mem_rdata & ~byte_mask(n_bytes)) | (r_wdata & byte_mask(n_bytes));
        n_status = ST_DONE;
        n_rdata  = '0;
        n_bres   = '0;
        n_rd_idx = r_rd_idx;
        n_wr_idx = r_wr_idx;
        case (r_cmd)
            CMD_PUT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    mem_req.wr_en = exec;
                    n_wr_idx      = next_idx(r_wr_idx, cnt);
                    n_bres        = n_bytes;
                end
            end
            CMD_GET: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_rdata  = mem_rdata & byte_mask(n_bytes);
                    n_bres   = n_bytes;
                    n_rd_idx = next_idx(r_rd_idx, cnt);
                end
            end
            CMD_PEEK_UNTIL, CMD_GET_UNTIL: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_rdata = mem_rdata & byte_mask(find_len);
                    n_bres  = find_idx;
                    if (r_cmd == CMD_GET_UNTIL) begin
                        n_rd_idx = next_idx(r_rd_idx, cnt);
                    end
                end
            end
            CMD_FLUSH: n_rd_idx = r_wr_idx;
            default:   n_status = ST_DONE;
        endcase
        occ_w = (n_wr_idx >= n_rd_idx) ? CNT_W'(n_wr_idx) - CNT_W'(n_rd_idx)
                                       : CNT_W'(n_wr_idx) + cnt - CNT_W'(n_rd_idx);
        n_occ = occ_w[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= CNT_W'(MAX_SLOTS);
            r_slot_bytes <= SB_W'(MAX_SLOT_BYTES);
            r_rd_idx     <= '0;
            r_wr_idx     <= '0;
        end else begin
            if (exec) begin
                r_rd_idx <= n_rd_idx;
                r_wr_idx <= n_wr_idx;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_SLOT_COUNT) begin
                    r_slot_count <= i_cfg_data;
                    r_rd_idx     <= '0;
                    r_wr_idx     <= '0;
                end else if (i_cfg_index == REG_SLOT_BYTES) begin
                    r_slot_bytes <= i_cfg_data[SB_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_status <= n_status;
            r_rdata  <= n_rdata;
            r_bres   <= n_bres;
            r_occ    <= n_occ;
            r_full   <= (next_idx(n_wr_idx, cnt) == n_rd_idx);
            r_empty  <= (n_rd_idx == n_wr_idx);
        end
    end

    assign m_axis_tuser = r_status;
    assign m_axis_tdata = {6'd0, r_empty, r_full, r_occ, r_bres, r_rdata};

    `SRB_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, s_accept, r_state == S_EXEC,
        "accepted request did not enter execution")
    `SRB_ASSERT_IMP(a_refused_zero, i_clk, i_rst_n, m_axis_tvalid && r_status != ST_DONE,
        r_rdata == '0 && r_bres == '0, "refused result carries data")
    `SRB_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, 1'b1,
        CNT_W'(r_rd_idx) < cnt && CNT_W'(r_wr_idx) < cnt, "ring index out of range")
    `SRB_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, m_axis_tvalid, !(r_full && r_empty),
        "ring reported full and empty")

endmodule

`default_nettype wire
